// ----- src/msie_pkg.sv -----
// msie_pkg: shared types and constants of the special integer execute unit
// function codes, stop codes and the control structs between top level and
// the multiply/divide sequencer; depends on nothing
package msie_pkg;

	localparam int XLEN = 32;

	// special-class function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_SLLV    = 6'h04;
	localparam logic [5:0] FN_SRLV    = 6'h06;
	localparam logic [5:0] FN_SRAV    = 6'h07;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_JALR    = 6'h09;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_BREAK   = 6'h0D;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MTHI    = 6'h11;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MTLO    = 6'h13;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_MULTU   = 6'h19;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_DIVU    = 6'h1B;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;

	// stop codes
	localparam logic [1:0] STOP_NONE    = 2'd0;
	localparam logic [1:0] STOP_SYSCALL = 2'd1;
	localparam logic [1:0] STOP_BREAK   = 2'd2;
	localparam logic [1:0] STOP_UNKNOWN = 2'd3;

	localparam logic [XLEN-1:0] LINK_OFFSET = 32'd8;

	// start request to the multiply/divide sequencer
	typedef struct packed {
		logic start;
		logic div;
		logic sgn;
	} md_req_t;

	// sequencer status back to the top level
	typedef struct packed {
		logic busy;
		logic done;
	} md_stat_t;

endpackage

// ----- src/msie_if.sv -----
// msie_if: valid/ready channel interfaces of the special integer execute unit
// one for instruction requests, one for results; depends on nothing
interface msie_cmd_if;
	logic        valid;
	logic        ready;
	logic [5:0]  op;
	logic [4:0]  shift_amount;
	logic [4:0]  dest_index;
	logic [31:0] src_a;
	logic [31:0] src_b;
	logic [31:0] insn_addr;

	modport source (output valid, op, shift_amount, dest_index, src_a, src_b, insn_addr,
		input ready);
	modport sink (input valid, op, shift_amount, dest_index, src_a, src_b, insn_addr,
		output ready);
endinterface

interface msie_res_if;
	logic        valid;
	logic        ready;
	logic        write_enable;
	logic [4:0]  write_index;
	logic [31:0] write_value;
	logic        jump;
	logic [31:0] jump_target;
	logic [1:0]  stop_code;

	modport source (output valid, write_enable, write_index, write_value, jump,
		jump_target, stop_code, input ready);
	modport sink (input valid, write_enable, write_index, write_value, jump,
		jump_target, stop_code, output ready);
endinterface

// ----- src/mips_special_integer_execute_unit.sv -----
// mips_special_integer_execute_unit: top level of the special-class execute unit
// alu, shifter and hi/lo moves plus the iterative multiply/divide
// depends on msie_pkg, msie_if and msie_muldiv
//
//   channel  dir  modport  payload
//   cmd      in   sink     op, shift_amount, dest_index, src_a, src_b, insn_addr
//   res      out  source   write_enable, write_index, write_value, jump,
//                          jump_target, stop_code
//
// shifts, alu ops, set-less-than, jumps, stops and hi/lo moves are registered
// on accept: a request is taken whenever the sequencer is idle and the result
// register is empty or being drained. mult/multu/div/divu give their (empty)
// result at once, then hold cmd.ready low while the shared 33-bit adder runs 32
// shift-add or restoring-divide steps and two sign fixup steps; hi/lo update
// at the end, so a following mfhi/mflo sees the new value.
// arst_n clears hi, lo, the result valid flag and the sequencer state.
// a stalled res side stalls cmd only when the result register is full.
module mips_special_integer_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	msie_cmd_if.sink    cmd,
	msie_res_if.source  res
);

	logic [31:0] hi_q;
	logic [31:0] lo_q;

	// result register
	logic        res_valid_q;
	logic        res_we_q;
	logic [4:0]  res_widx_q;
	logic [31:0] res_wval_q;
	logic        res_jmp_q;
	logic [31:0] res_jtgt_q;
	logic [1:0]  res_stop_q;

	logic               cmd_acc;
	logic               is_md;
	msie_pkg::md_req_t  md_req;
	msie_pkg::md_stat_t md_stat;
	logic [31:0]        md_hi;
	logic [31:0]        md_lo;

	// decoded result of the current request
	logic        wr;
	logic        jmp;
	logic [31:0] val;
	logic [1:0]  stop;
	logic [4:0]  shamt;

	// ready when the sequencer is free and the result register can take a new item
	assign cmd.ready = !md_stat.busy && (!res_valid_q || res.ready);
	assign cmd_acc   = cmd.valid && cmd.ready;

	assign is_md = (cmd.op == msie_pkg::FN_MULT) || (cmd.op == msie_pkg::FN_MULTU)
		|| (cmd.op == msie_pkg::FN_DIV) || (cmd.op == msie_pkg::FN_DIVU);

	assign md_req.start = cmd_acc && is_md;
	assign md_req.div   = (cmd.op == msie_pkg::FN_DIV) || (cmd.op == msie_pkg::FN_DIVU);
	assign md_req.sgn   = (cmd.op == msie_pkg::FN_MULT) || (cmd.op == msie_pkg::FN_DIV);

	msie_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.opa    (cmd.src_a),
		.opb    (cmd.src_b),
		.stat   (md_stat),
		.hi_res (md_hi),
		.lo_res (md_lo)
	);

	// variable shifts take their count from the low bits of src_a
	assign shamt = cmd.op[2] ? cmd.src_a[4:0] : cmd.shift_amount;

	always_comb begin
		wr   = 1'b0;
		jmp  = 1'b0;
		val  = '0;
		stop = msie_pkg::STOP_NONE;
		unique case (cmd.op) inside
			msie_pkg::FN_SLL, msie_pkg::FN_SLLV: begin
				wr  = 1'b1;
				val = cmd.src_b << shamt;
			end
			msie_pkg::FN_SRL, msie_pkg::FN_SRLV: begin
				wr  = 1'b1;
				val = cmd.src_b >> shamt;
			end
			msie_pkg::FN_SRA, msie_pkg::FN_SRAV: begin
				wr  = 1'b1;
				val = $unsigned($signed(cmd.src_b) >>> shamt);
			end
			msie_pkg::FN_JR: begin
				jmp = 1'b1;
			end
			msie_pkg::FN_JALR: begin
				wr  = 1'b1;
				jmp = 1'b1;
				val = cmd.insn_addr + msie_pkg::LINK_OFFSET;
			end
			msie_pkg::FN_SYSCALL: stop = msie_pkg::STOP_SYSCALL;
			msie_pkg::FN_BREAK:   stop = msie_pkg::STOP_BREAK;
			msie_pkg::FN_MFHI: begin
				wr  = 1'b1;
				val = hi_q;
			end
			msie_pkg::FN_MFLO: begin
				wr  = 1'b1;
				val = lo_q;
			end
			msie_pkg::FN_MTHI, msie_pkg::FN_MTLO, msie_pkg::FN_MULT, msie_pkg::FN_MULTU,
			msie_pkg::FN_DIV, msie_pkg::FN_DIVU: begin
				wr = 1'b0;
			end
			msie_pkg::FN_ADD, msie_pkg::FN_ADDU: begin
				wr  = 1'b1;
				val = cmd.src_a + cmd.src_b;
			end
			msie_pkg::FN_SUB, msie_pkg::FN_SUBU: begin
				wr  = 1'b1;
				val = cmd.src_a - cmd.src_b;
			end
			msie_pkg::FN_AND: begin
				wr  = 1'b1;
				val = cmd.src_a & cmd.src_b;
			end
			msie_pkg::FN_OR: begin
				wr  = 1'b1;
				val = cmd.src_a | cmd.src_b;
			end
			msie_pkg::FN_XOR: begin
				wr  = 1'b1;
				val = cmd.src_a ^ cmd.src_b;
			end
			msie_pkg::FN_NOR: begin
				wr  = 1'b1;
				val = ~(cmd.src_a | cmd.src_b);
			end
			msie_pkg::FN_SLT: begin
				wr  = 1'b1;
				val = {31'b0, $signed(cmd.src_a) < $signed(cmd.src_b)};
			end
			msie_pkg::FN_SLTU: begin
				wr  = 1'b1;
				val = {31'b0, cmd.src_a < cmd.src_b};
			end
			default: stop = msie_pkg::STOP_UNKNOWN;
		endcase
		// register zero is never written
		if (cmd.dest_index == 5'd0) begin
			wr = 1'b0;
		end
	end

	// hi/lo: moves on accept, multiply/divide results when the sequencer finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (md_stat.done) begin
			hi_q <= md_hi;
			lo_q <= md_lo;
		end else if (cmd_acc && (cmd.op == msie_pkg::FN_MTHI)) begin
			hi_q <= cmd.src_a;
		end else if (cmd_acc && (cmd.op == msie_pkg::FN_MTLO)) begin
			lo_q <= cmd.src_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_acc) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, zeroed where nothing is written or jumped
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			res_we_q   <= wr;
			res_widx_q <= wr ? cmd.dest_index : 5'd0;
			res_wval_q <= wr ? val : 32'd0;
			res_jmp_q  <= jmp;
			res_jtgt_q <= jmp ? cmd.src_a : 32'd0;
			res_stop_q <= stop;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.write_enable = res_we_q;
	assign res.write_index  = res_widx_q;
	assign res.write_value  = res_wval_q;
	assign res.jump         = res_jmp_q;
	assign res.jump_target  = res_jtgt_q;
	assign res.stop_code    = res_stop_q;

	// no request taken while the sequencer owns hi/lo
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		md_stat.busy |-> !cmd.ready)
		else $error("request taken while multiply/divide busy");

	// a multiply/divide request starts the sequencer
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |=> md_stat.busy)
		else $error("sequencer did not start");

	// the sequencer returns to idle right after delivering hi/lo
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md_stat.done |=> !md_stat.busy)
		else $error("sequencer still busy after done");

	// register zero never shows up as a write
	a_no_r0: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_we_q) |-> (res_widx_q != 5'd0))
		else $error("write to register zero");

endmodule

// ----- src/msie_muldiv.sv -----
// msie_muldiv: iterative multiply/divide sequencer around one 33-bit adder
// radix-2 shift-add multiply, restoring divide, two sign fixup steps
// depends on msie_pkg
module msie_muldiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  msie_pkg::md_req_t              req,
	input  logic [msie_pkg::XLEN-1:0]      opa,
	input  logic [msie_pkg::XLEN-1:0]      opb,
	output msie_pkg::md_stat_t             stat,
	output logic [msie_pkg::XLEN-1:0]      hi_res,
	output logic [msie_pkg::XLEN-1:0]      lo_res
);

	localparam int W     = msie_pkg::XLEN;
	localparam int CNT_W = $clog2(W);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RUN    = 4'b0010,
		ST_FIX_LO = 4'b0100,
		ST_FIX_HI = 4'b1000
	} md_state_t;

	md_state_t        state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             div_q;
	logic             neg_lo_q;
	logic             neg_hi_q;
	logic             carry_q;
	logic [W-1:0]     hi_q;
	logic [W-1:0]     lo_q;
	logic [W-1:0]     dvsr_q;

	logic [W:0]       add_a;
	logic [W:0]       add_b;
	logic             add_cin;
	logic [W+1:0]     sum;
	logic [W-1:0]     mag_a;
	logic [W-1:0]     mag_b;

	assign mag_a = (req.sgn && opa[W-1]) ? (~opa + 1'b1) : opa;
	assign mag_b = (req.sgn && opb[W-1]) ? (~opb + 1'b1) : opb;

	// the one shared adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_cin = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				if (div_q) begin
					add_a   = {hi_q, lo_q[W-1]};
					add_b   = ~{1'b0, dvsr_q};
					add_cin = 1'b1;
				end else begin
					add_a = {1'b0, hi_q};
					add_b = lo_q[0] ? {1'b0, dvsr_q} : '0;
				end
			end
			ST_FIX_LO: begin
				add_a   = {1'b0, ~lo_q};
				add_cin = 1'b1;
			end
			ST_FIX_HI: begin
				add_a   = {1'b0, ~hi_q};
				add_cin = div_q ? 1'b1 : carry_q;
			end
			ST_IDLE: begin
				add_cin = 1'b0;
			end
			default: begin
				add_cin = 1'b0;
			end
		endcase
		sum = {1'b0, add_a} + {1'b0, add_b} + {{(W+1){1'b0}}, add_cin};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(W - 1)) begin
						state_q <= ST_FIX_LO;
					end
				end
				ST_FIX_LO: state_q <= ST_FIX_HI;
				ST_FIX_HI: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					hi_q     <= '0;
					lo_q     <= mag_a;
					dvsr_q   <= mag_b;
					div_q    <= req.div;
					neg_lo_q <= req.sgn && (opa[W-1] ^ opb[W-1]);
					neg_hi_q <= req.div ? (req.sgn && opa[W-1])
						: (req.sgn && (opa[W-1] ^ opb[W-1]));
				end
			end
			ST_RUN: begin
				if (div_q) begin
					// restoring step: keep the difference when there is no borrow
					if (sum[W+1]) begin
						hi_q <= sum[W-1:0];
						lo_q <= {lo_q[W-2:0], 1'b1};
					end else begin
						hi_q <= {hi_q[W-2:0], lo_q[W-1]};
						lo_q <= {lo_q[W-2:0], 1'b0};
					end
				end else begin
					hi_q <= sum[W:1];
					lo_q <= {sum[0], lo_q[W-1:1]};
				end
			end
			ST_FIX_LO: begin
				carry_q <= sum[W];
				if (neg_lo_q) begin
					lo_q <= sum[W-1:0];
				end
			end
			default: begin
				carry_q <= carry_q;
			end
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_FIX_HI);
	assign hi_res    = neg_hi_q ? sum[W-1:0] : hi_q;
	assign lo_res    = lo_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for mips_special_integer_execute_unit
// drives instruction requests, predicts register write, jump and stop results
// depends on msie_pkg, msie_if and the execute unit rtl
module tb_top;

	// one result as seen on the res channel, in port order
	typedef struct packed {
		logic        write_enable;
		logic [4:0]  write_index;
		logic [31:0] write_value;
		logic        jump;
		logic [31:0] jump_target;
		logic [1:0]  stop_code;
	} exec_result_t;

	// one instruction request; fixed marks a row whose result is typed in
	typedef struct {
		logic [5:0]   op;
		logic [4:0]   shift_amount;
		logic [4:0]   dest_index;
		logic [31:0]  src_a;
		logic [31:0]  src_b;
		logic [31:0]  insn_addr;
		bit           fixed;
		exec_result_t fixed_result;
	} instr_t;

	// highest function code, not decoded by the unit
	localparam logic [5:0] FN_TOP_UNUSED = 6'h3F;
	localparam int RANDOM_INSTRS = 1500;
	// generous ceiling for the whole run, the long stall included
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	msie_cmd_if cmd_ch ();
	msie_res_if res_ch ();

	mips_special_integer_execute_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hi/lo as the predictor sees them
	logic [31:0] hi_model = '0;
	logic [31:0] lo_model = '0;

	exec_result_t pending_results[$];
	int mismatches = 0;
	int cycle_count = 0;

	// typed-in result of the request on offer, driven with its payload
	bit           offer_fixed = 1'b0;
	exec_result_t offer_result = '0;

	instr_t directed_rows[$];
	logic [5:0] known_ops [0:27];

	// predicted outcome of one special instruction, updates hi/lo
	function automatic exec_result_t execute_special(instr_t ins);
		exec_result_t r;
		logic [31:0] a, b, val, qm, rm, ma, mb;
		logic [63:0] uprod;
		longint sprod;
		logic [4:0] vsh;
		bit wr, jmp;
		logic [1:0] stop;
		a = ins.src_a;
		b = ins.src_b;
		vsh = a[4:0];
		wr = 1'b0;
		jmp = 1'b0;
		val = '0;
		stop = msie_pkg::STOP_NONE;
		case (ins.op)
			msie_pkg::FN_SLL: begin wr = 1'b1; val = b << ins.shift_amount; end
			msie_pkg::FN_SRL: begin wr = 1'b1; val = b >> ins.shift_amount; end
			msie_pkg::FN_SRA: begin wr = 1'b1; val = $signed(b) >>> ins.shift_amount; end
			msie_pkg::FN_SLLV: begin wr = 1'b1; val = b << vsh; end
			msie_pkg::FN_SRLV: begin wr = 1'b1; val = b >> vsh; end
			msie_pkg::FN_SRAV: begin wr = 1'b1; val = $signed(b) >>> vsh; end
			msie_pkg::FN_JR: jmp = 1'b1;
			msie_pkg::FN_JALR: begin
				wr = 1'b1;
				val = ins.insn_addr + msie_pkg::LINK_OFFSET;
				jmp = 1'b1;
			end
			msie_pkg::FN_SYSCALL: stop = msie_pkg::STOP_SYSCALL;
			msie_pkg::FN_BREAK: stop = msie_pkg::STOP_BREAK;
			msie_pkg::FN_MFHI: begin wr = 1'b1; val = hi_model; end
			msie_pkg::FN_MTHI: hi_model = a;
			msie_pkg::FN_MFLO: begin wr = 1'b1; val = lo_model; end
			msie_pkg::FN_MTLO: lo_model = a;
			msie_pkg::FN_MULT: begin
				sprod = longint'($signed(a)) * longint'($signed(b));
				lo_model = sprod[31:0];
				hi_model = sprod[63:32];
			end
			msie_pkg::FN_MULTU: begin
				uprod = {32'b0, a} * {32'b0, b};
				lo_model = uprod[31:0];
				hi_model = uprod[63:32];
			end
			msie_pkg::FN_DIV: begin
				if (b == 32'd0) begin
					// divide by zero: remainder is the dividend
					hi_model = a;
					lo_model = a[31] ? 32'd1 : 32'hffff_ffff;
				end else if (a == 32'h8000_0000 && b == 32'hffff_ffff) begin
					lo_model = 32'h8000_0000;
					hi_model = 32'd0;
				end else begin
					// magnitudes, then truncate toward zero
					ma = a[31] ? -a : a;
					mb = b[31] ? -b : b;
					qm = ma / mb;
					rm = ma % mb;
					if (a[31] ^ b[31]) qm = -qm;
					if (a[31]) rm = -rm;
					lo_model = qm;
					hi_model = rm;
				end
			end
			msie_pkg::FN_DIVU: begin
				if (b == 32'd0) begin
					hi_model = a;
					lo_model = 32'hffff_ffff;
				end else begin
					lo_model = a / b;
					hi_model = a % b;
				end
			end
			msie_pkg::FN_ADD, msie_pkg::FN_ADDU: begin wr = 1'b1; val = a + b; end
			msie_pkg::FN_SUB, msie_pkg::FN_SUBU: begin wr = 1'b1; val = a - b; end
			msie_pkg::FN_AND: begin wr = 1'b1; val = a & b; end
			msie_pkg::FN_OR: begin wr = 1'b1; val = a | b; end
			msie_pkg::FN_XOR: begin wr = 1'b1; val = a ^ b; end
			msie_pkg::FN_NOR: begin wr = 1'b1; val = ~(a | b); end
			msie_pkg::FN_SLT: begin
				wr = 1'b1;
				val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			end
			msie_pkg::FN_SLTU: begin wr = 1'b1; val = (a < b) ? 32'd1 : 32'd0; end
			default: stop = msie_pkg::STOP_UNKNOWN;
		endcase
		// writes to r0 vanish entirely
		if (ins.dest_index == 5'd0) wr = 1'b0;
		r.write_enable = wr;
		r.write_index = wr ? ins.dest_index : 5'd0;
		r.write_value = wr ? val : 32'd0;
		r.jump = jmp;
		r.jump_target = jmp ? a : 32'd0;
		r.stop_code = stop;
		return r;
	endfunction

	function automatic exec_result_t reg_write(logic [4:0] idx, logic [31:0] val);
		exec_result_t r;
		r = '0;
		r.write_enable = 1'b1;
		r.write_index = idx;
		r.write_value = val;
		return r;
	endfunction

	function automatic exec_result_t stop_only(logic [1:0] code);
		exec_result_t r;
		r = '0;
		r.stop_code = code;
		return r;
	endfunction

	function automatic void add_row(logic [5:0] op, logic [4:0] sh, logic [4:0] rd,
			logic [31:0] a, logic [31:0] b, logic [31:0] pc, bit fixed, exec_result_t res);
		instr_t ins;
		ins.op = op;
		ins.shift_amount = sh;
		ins.dest_index = rd;
		ins.src_a = a;
		ins.src_b = b;
		ins.insn_addr = pc;
		ins.fixed = fixed;
		ins.fixed_result = res;
		directed_rows.push_back(ins);
	endfunction

	// operand mix: extremes, small values around zero, and full random
	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'd0;
			1: v = 32'hffff_ffff;
			2: v = 32'h8000_0000;
			3: v = 32'h7fff_ffff;
			4: v = $urandom_range(0, 40);
			5: v = -$urandom_range(1, 40);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic instr_t random_instr();
		instr_t ins;
		// mostly decoded codes, now and then any code at all
		if ($urandom_range(0, 9) == 0)
			ins.op = 6'($urandom_range(0, 63));
		else
			ins.op = known_ops[5'($urandom_range(0, 27))];
		ins.shift_amount = 5'($urandom_range(0, 31));
		ins.dest_index = 5'($urandom_range(0, 31));
		ins.src_a = pick_operand();
		ins.src_b = pick_operand();
		ins.insn_addr = $urandom;
		// push the divider into its corner cases more often
		if (ins.op == msie_pkg::FN_DIV || ins.op == msie_pkg::FN_DIVU) begin
			case ($urandom_range(0, 9))
				0, 1: ins.src_b = 32'd0;
				2: begin
					ins.src_a = 32'h8000_0000;
					ins.src_b = 32'hffff_ffff;
				end
				default: ;
			endcase
		end
		ins.fixed = 1'b0;
		ins.fixed_result = '0;
		return ins;
	endfunction

	// offer one request after an idle gap and hold it until taken
	task automatic send_request(instr_t ins, int gap);
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.op = ins.op;
		cmd_ch.shift_amount = ins.shift_amount;
		cmd_ch.dest_index = ins.dest_index;
		cmd_ch.src_a = ins.src_a;
		cmd_ch.src_b = ins.src_b;
		cmd_ch.insn_addr = ins.insn_addr;
		offer_fixed = ins.fixed;
		offer_result = ins.fixed_result;
		cmd_ch.valid = 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_all_results();
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// result checking first, then prediction of the request taken at this edge;
	// a result leaving now always belongs to an earlier request
	always @(posedge clk) begin : result_monitor
		exec_result_t want, got, pred;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got.write_enable = res_ch.write_enable;
				got.write_index = res_ch.write_index;
				got.write_value = res_ch.write_value;
				got.jump = res_ch.jump;
				got.jump_target = res_ch.jump_target;
				got.stop_code = res_ch.stop_code;
				if (pending_results.size() == 0) begin
					$error("result with no request waiting: %h", got);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (got.write_enable !== want.write_enable) begin
						$error("write_enable: expected %0d, got %0d",
							want.write_enable, got.write_enable);
						mismatches++;
					end
					if (got.write_index !== want.write_index) begin
						$error("write_index: expected %0d, got %0d",
							want.write_index, got.write_index);
						mismatches++;
					end
					if (got.write_value !== want.write_value) begin
						$error("write_value: expected %h, got %h",
							want.write_value, got.write_value);
						mismatches++;
					end
					if (got.jump !== want.jump) begin
						$error("jump: expected %0d, got %0d", want.jump, got.jump);
						mismatches++;
					end
					if (got.jump_target !== want.jump_target) begin
						$error("jump_target: expected %h, got %h",
							want.jump_target, got.jump_target);
						mismatches++;
					end
					if (got.stop_code !== want.stop_code) begin
						$error("stop_code: expected %0d, got %0d",
							want.stop_code, got.stop_code);
						mismatches++;
					end
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				pred = execute_special('{cmd_ch.op, cmd_ch.shift_amount, cmd_ch.dest_index,
					cmd_ch.src_a, cmd_ch.src_b, cmd_ch.insn_addr, 1'b0, '0});
				// typed-in rows still advance hi/lo through the predictor
				pending_results.push_back(offer_fixed ? offer_result : pred);
			end
		end
	end

	// result side: random backpressure, a quiet stretch and one long hold
	initial begin : result_drain
		int taken;
		int gap;
		taken = 0;
		res_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = (taken >= 900 && taken < 1050) ? 0 : $urandom_range(0, 10);
			// long hold so the result register fills and cmd stalls
			if (taken == 500) gap = LONG_HOLD;
			if (gap > 0) begin
				res_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			taken++;
			@(negedge clk);
		end
	end

	// request side: reset, directed table, random stream, drain
	initial begin : request_stream
		instr_t ins;
		int gap;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = msie_pkg::FN_SLL;
		cmd_ch.shift_amount = '0;
		cmd_ch.dest_index = '0;
		cmd_ch.src_a = '0;
		cmd_ch.src_b = '0;
		cmd_ch.insn_addr = '0;
		known_ops = '{msie_pkg::FN_SLL, msie_pkg::FN_SRL, msie_pkg::FN_SRA,
			msie_pkg::FN_SLLV, msie_pkg::FN_SRLV, msie_pkg::FN_SRAV, msie_pkg::FN_JR,
			msie_pkg::FN_JALR, msie_pkg::FN_SYSCALL, msie_pkg::FN_BREAK,
			msie_pkg::FN_MFHI, msie_pkg::FN_MTHI, msie_pkg::FN_MFLO, msie_pkg::FN_MTLO,
			msie_pkg::FN_MULT, msie_pkg::FN_MULTU, msie_pkg::FN_DIV, msie_pkg::FN_DIVU,
			msie_pkg::FN_ADD, msie_pkg::FN_ADDU, msie_pkg::FN_SUB, msie_pkg::FN_SUBU,
			msie_pkg::FN_AND, msie_pkg::FN_OR, msie_pkg::FN_XOR, msie_pkg::FN_NOR,
			msie_pkg::FN_SLT, msie_pkg::FN_SLTU};

		// hi/lo read straight after reset
		add_row(msie_pkg::FN_MFHI, 5'd0, 5'd1, '1, '1, '1, 1'b1, reg_write(5'd1, 32'd0));
		// shift count extremes
		add_row(msie_pkg::FN_SLL, 5'd31, 5'd31, '0, 32'd1, '0, 1'b1,
			reg_write(5'd31, 32'h8000_0000));
		add_row(msie_pkg::FN_SRA, 5'd31, 5'd5, '0, 32'h8000_0000, '0, 1'b1,
			reg_write(5'd5, '1));
		add_row(msie_pkg::FN_SRL, 5'd0, 5'd2, '0, '1, '1, 1'b1, reg_write(5'd2, '1));
		// variable shift uses only the low five bits of src_a
		add_row(msie_pkg::FN_SLLV, 5'd31, 5'd6, 32'hffff_ffe1, 32'h8000_0001, '0, 1'b0, '0);
		// add and sub wrap without a trap
		add_row(msie_pkg::FN_ADD, 5'd0, 5'd3, '1, 32'd1, '0, 1'b1, reg_write(5'd3, 32'd0));
		add_row(msie_pkg::FN_SUB, 5'd0, 5'd4, '0, 32'd1, '0, 1'b1, reg_write(5'd4, '1));
		add_row(msie_pkg::FN_NOR, 5'd0, 5'd9, '0, '0, '0, 1'b1, reg_write(5'd9, '1));
		add_row(msie_pkg::FN_SLT, 5'd0, 5'd11, 32'h8000_0000, 32'h7fff_ffff, '0, 1'b1,
			reg_write(5'd11, 32'd1));
		add_row(msie_pkg::FN_SLTU, 5'd0, 5'd12, 32'h8000_0000, 32'h7fff_ffff, '0, 1'b1,
			reg_write(5'd12, 32'd0));
		add_row(msie_pkg::FN_JR, 5'd0, 5'd0, '1, '0, '0, 1'b1,
			'{1'b0, 5'd0, 32'd0, 1'b1, '1, msie_pkg::STOP_NONE});
		// link value wraps past the top of the address space
		add_row(msie_pkg::FN_JALR, 5'd0, 5'd31, 32'd4, '0, 32'hffff_fff8, 1'b1,
			'{1'b1, 5'd31, 32'd0, 1'b1, 32'd4, msie_pkg::STOP_NONE});
		add_row(msie_pkg::FN_SYSCALL, 5'd31, 5'd13, '1, '1, '0, 1'b1,
			stop_only(msie_pkg::STOP_SYSCALL));
		add_row(msie_pkg::FN_BREAK, 5'd0, 5'd14, '1, '1, '0, 1'b1,
			stop_only(msie_pkg::STOP_BREAK));
		add_row(FN_TOP_UNUSED, 5'd31, 5'd31, '1, '1, '1, 1'b1,
			stop_only(msie_pkg::STOP_UNKNOWN));
		// destination zero drops the write
		add_row(msie_pkg::FN_ADDU, 5'd0, 5'd0, 32'h1234_5678, 32'h1111_1111, '0, 1'b1, '0);
		// signed and unsigned products at the extremes
		add_row(msie_pkg::FN_MULT, 5'd0, 5'd16, 32'h8000_0000, 32'h8000_0000, '0, 1'b1, '0);
		add_row(msie_pkg::FN_MFHI, 5'd0, 5'd17, '0, '0, '0, 1'b1,
			reg_write(5'd17, 32'h4000_0000));
		add_row(msie_pkg::FN_MULTU, 5'd0, 5'd18, '1, '1, '0, 1'b1, '0);
		add_row(msie_pkg::FN_MFLO, 5'd0, 5'd18, '0, '0, '0, 1'b1, reg_write(5'd18, 32'd1));
		// divide by zero with a negative dividend
		add_row(msie_pkg::FN_DIV, 5'd0, 5'd19, 32'h8000_0000, '0, '0, 1'b1, '0);
		add_row(msie_pkg::FN_MFLO, 5'd0, 5'd19, '0, '0, '0, 1'b1, reg_write(5'd19, 32'd1));
		add_row(msie_pkg::FN_DIVU, 5'd0, 5'd20, 32'd5, '0, '0, 1'b1, '0);
		add_row(msie_pkg::FN_MFHI, 5'd0, 5'd20, '0, '0, '0, 1'b1, reg_write(5'd20, 32'd5));
		// signed minimum over minus one
		add_row(msie_pkg::FN_DIV, 5'd0, 5'd21, 32'h8000_0000, '1, '0, 1'b1, '0);
		add_row(msie_pkg::FN_MFLO, 5'd0, 5'd21, '0, '0, '0, 1'b1,
			reg_write(5'd21, 32'h8000_0000));

		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i], $urandom_range(0, 10));

		// let everything drain before the random stream
		cmd_ch.valid = 1'b0;
		wait_all_results();

		for (int n = 0; n < RANDOM_INSTRS; n++) begin
			ins = random_instr();
			gap = (n >= 300 && n < 450) ? 0 : $urandom_range(0, 10);
			if (n == 750) begin
				cmd_ch.valid = 1'b0;
				wait_all_results();
			end
			send_request(ins, gap);
		end
		cmd_ch.valid = 1'b0;

		wait_all_results();
		// a trailing multiply/divide may still be running
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			$error("results still expected at end: %0d", pending_results.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/msie_pkg.sv
src/msie_if.sv
src/msie_muldiv.sv
src/mips_special_integer_execute_unit.sv
tb/tb_top.sv
